// File: hw/rtl/ptp_pkg.sv
// Shared types, codes and unit widths for the point-to-point motion profile block.
package ptp_pkg;

	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_ARM   = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	localparam int MUL_A_W = 48;
	localparam int MUL_B_W = 32;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int DIV_N_W = 48;
	localparam int DIV_D_W = 32;
	localparam int SQ_RT_W = 32;
	localparam int SQ_IN_W = 2 * SQ_RT_W;

	localparam logic [16:0] TIME_STEP_RESET = 17'd655;

	typedef struct packed {
		logic [1:0]         func;
		logic [1:0]         axis;
		logic signed [31:0] start_pos;
		logic signed [31:0] end_pos;
		logic [30:0]        accel_limit;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         out_axis;
		logic signed [31:0] position;
		logic signed [31:0] velocity;
		logic signed [31:0] acceleration;
		logic               done_res;
		logic               last;
	} setpoint_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ARM_PREP,
		ST_ARM_MUL_AD,
		ST_ARM_SQRT,
		ST_ARM_DIV_T,
		ST_ARM_MUL_TT,
		ST_ARM_MUL_SA,
		ST_ARM_DIV_C,
		ST_ARM_WRITE,
		ST_TK_SCAN,
		ST_TK_LOAD,
		ST_TK_PHASE,
		ST_TK_MUL,
		ST_TK_SIGN,
		ST_TK_OUT
	} state_t;

	typedef enum logic [1:0] {
		PH_ACCEL,
		PH_CRUISE,
		PH_BRAKE,
		PH_DONE
	} phase_t;

endpackage

// File: hw/rtl/ptp_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module ptp_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ptp_pkg::MUL_A_W-1:0]   a,
	input  logic [ptp_pkg::MUL_B_W-1:0]   b,
	output logic                          done,
	output logic [ptp_pkg::MUL_P_W-1:0]   prod
);
	localparam int A_W   = ptp_pkg::MUL_A_W;
	localparam int B_W   = ptp_pkg::MUL_B_W;
	localparam int P_W   = ptp_pkg::MUL_P_W;
	localparam int CNT_W = $clog2(B_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [A_W-1:0]   a_q;
	logic [P_W-1:0]   prod_q;
	logic [A_W:0]     sum;

	// The upper half accumulates; the multiplier bits leave at the bottom.
	assign sum  = {1'b0, prod_q[P_W-1:B_W]} + {1'b0, (prod_q[0] ? a_q : {A_W{1'b0}})};
	assign done = done_q;
	assign prod = prod_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(B_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= a;
			prod_q <= {{A_W{1'b0}}, b};
		end else if (busy_q) begin
			prod_q <= {sum, prod_q[B_W-1:1]};
		end
	end

endmodule

// File: hw/rtl/ptp_div.sv
// Restoring divider, one quotient bit per cycle, floored quotient.
module ptp_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ptp_pkg::DIV_N_W-1:0]   num,
	input  logic [ptp_pkg::DIV_D_W-1:0]   den,
	output logic                          done,
	output logic [ptp_pkg::DIV_N_W-1:0]   quo
);
	localparam int N_W   = ptp_pkg::DIV_N_W;
	localparam int D_W   = ptp_pkg::DIV_D_W;
	localparam int CNT_W = $clog2(N_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [D_W-1:0]   den_q;
	logic [D_W-1:0]   rem_q;
	logic [N_W-1:0]   quo_q;
	logic [D_W:0]     shifted;
	logic [D_W:0]     diff;
	logic             ge;

	assign shifted = {rem_q, quo_q[N_W-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign ge      = shifted >= {1'b0, den_q};
	assign done    = done_q;
	assign quo     = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(N_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= ge ? diff[D_W-1:0] : shifted[D_W-1:0];
			quo_q <= {quo_q[N_W-2:0], ge};
		end
	end

endmodule

// File: hw/rtl/ptp_sqrt.sv
// Digit-by-digit integer square root, two radicand bits and one root bit per cycle.
module ptp_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ptp_pkg::SQ_IN_W-1:0]   x,
	output logic                          done,
	output logic [ptp_pkg::SQ_RT_W-1:0]   root
);
	localparam int IN_W  = ptp_pkg::SQ_IN_W;
	localparam int RT_W  = ptp_pkg::SQ_RT_W;
	localparam int CNT_W = $clog2(RT_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [IN_W-1:0]  x_q;
	logic [RT_W-1:0]  root_q;
	logic [RT_W+1:0]  rem_q;
	logic [RT_W+3:0]  shifted;
	logic [RT_W+3:0]  trial;
	logic [RT_W+3:0]  diff;
	logic             ge;

	assign shifted = {rem_q, x_q[IN_W-1 -: 2]};
	assign trial   = {2'b00, root_q, 2'b01};
	assign diff    = shifted - trial;
	assign ge      = shifted >= trial;
	assign done    = done_q;
	assign root    = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(RT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= x;
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[IN_W-3:0], 2'b00};
			rem_q  <= ge ? diff[RT_W+1:0] : shifted[RT_W+1:0];
			root_q <= {root_q[RT_W-2:0], ge};
		end
	end

endmodule

// File: hw/rtl/point_to_point_motion_profile.sv
// Top level of the multi-axis point-to-point trapezoidal setpoint generator.
//
// This block keeps a trapezoidal motion profile for each of AXES axes in Q16.16
// fixed point. An arm item loads one axis with start, end and acceleration limit,
// works out peak speed, ramp time, ramp distance and total time, and marks the axis
// active; a clear item deactivates an axis; a tick item emits one setpoint per
// active axis in rising axis order, the last one flagged, and then advances that
// axis's elapsed time by the time_step register. An axis whose time has run out
// reports its end point with zero velocity, flags done and goes inactive. Items are
// handled one at a time and cmd_stall stays high while one is in work. All wide
// arithmetic runs on three serial units: a shift-and-add multiplier, a restoring divider
// and a digit-by-digit square root. An arm skips them when the distance or the
// acceleration is zero, a clear or an ignored item never raises cmd_stall, and a tick
// uses, per active axis, one product while cruising or finishing, three while
// accelerating and four while braking. One setpoint waits in the output register, so
// the block keeps working while the downstream side stalls, until the next setpoint is
// ready. The time_step register is written through the cfg port, which is always
// ready.
module point_to_point_motion_profile #(
	parameter int AXES = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  ptp_pkg::cmd_t      cmd,
	output logic               set_valid,
	input  logic               set_stall,
	output ptp_pkg::setpoint_t setpoint,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [16:0]        cfg_data
);
	localparam int AX_W = (AXES > 1) ? $clog2(AXES) : 1;
	localparam int AC_W = AX_W + 1;
	localparam int A_W  = ptp_pkg::MUL_A_W;
	localparam int B_W  = ptp_pkg::MUL_B_W;
	localparam int P_W  = ptp_pkg::MUL_P_W;
	localparam int N_W  = ptp_pkg::DIV_N_W;
	localparam int D_W  = ptp_pkg::DIV_D_W;
	localparam int SI_W = ptp_pkg::SQ_IN_W;
	localparam int SR_W = ptp_pkg::SQ_RT_W;

	function automatic logic signed [31:0] sat32(input logic signed [44:0] x);
		logic signed [31:0] r;
		if (x > 45'sd2147483647) r = 32'sh7FFFFFFF;
		else if (x < -45'sd2147483648) r = 32'sh80000000;
		else r = x[31:0];
		return r;
	endfunction

	// Control state.
	ptp_pkg::state_t     state_q, state_d;
	logic                issued_q;
	logic [AC_W-1:0]     ax_q;
	logic [1:0]          step_q;
	logic [16:0]         time_step_q;
	logic                set_valid_q;
	ptp_pkg::setpoint_t  setpoint_q;
	ptp_pkg::cmd_t       cmd_q;

	// Per-axis storage.
	logic [AXES-1:0]     active_q;
	logic [AXES-1:0]     sign_q;
	logic signed [31:0]  origin_q  [AXES];
	logic [30:0]         accel_q   [AXES];
	logic [31:0]         total_q   [AXES];
	logic [31:0]         elapsed_q [AXES];
	logic [31:0]         peak_q    [AXES];
	logic [31:0]         ramp_t_q  [AXES];
	logic [31:0]         ramp_d_q  [AXES];

	// Arm working registers.
	logic [31:0]         d_q;
	logic                neg_q;
	logic [31:0]         vmax_q;
	logic [31:0]         tacc_q;
	logic [31:0]         sacc_q;
	logic [31:0]         tconst_q;
	logic [47:0]         tmp_q;

	// Tick working registers.
	logic [31:0]         t_q, r_q, tt_q, v_q, sa_q, cr_q, dt_q, left_q;
	logic [30:0]         a_q;
	logic signed [31:0]  org_q;
	logic                sgn_q;
	ptp_pkg::phase_t     phase_q;
	logic signed [43:0]  pos_q;
	logic signed [43:0]  vel_q;
	logic signed [32:0]  acc_q;

	// Serial unit hookup.
	logic                mul_start, div_start, sq_start;
	logic [A_W-1:0]      mul_a;
	logic [B_W-1:0]      mul_b;
	logic [N_W-1:0]      div_num;
	logic [D_W-1:0]      div_den;
	logic [SI_W-1:0]     sq_x;
	logic                mul_done, div_done, sq_done, op_done;
	logic [P_W-1:0]      mul_prod;
	logic [N_W-1:0]      div_quo;
	logic [SR_W-1:0]     sq_root;
	logic                need_op;

	// Shared combinational helpers.
	logic                cmd_accept;
	logic                cmd_axis_ok;
	logic [AX_W-1:0]     ax_idx;
	logic [AX_W-1:0]     cmd_idx;
	logic [AX_W-1:0]     in_idx;
	logic                out_free;
	logic [63:0]         x16;
	logic [62:0]         x17;
	logic [40:0]         cap16;
	logic [40:0]         cap17;
	logic [31:0]         prod_clamp17;
	logic [31:0]         quo_clamp;
	logic signed [32:0]  arm_diff;
	logic [31:0]         arm_dist;
	logic [32:0]         twice_sacc;
	logic [31:0]         sconst;
	logic [33:0]         tt_sum;
	logic [31:0]         tt_arm;
	logic [32:0]         sum_tr;
	logic [32:0]         two_r;
	logic [32:0]         cr_full;
	logic [32:0]         el_sum;
	logic                later_active;
	logic                last_step;
	logic signed [44:0]  pos_full;

	assign cmd_stall   = (state_q != ptp_pkg::ST_IDLE);
	assign cmd_accept  = cmd_valid && !cmd_stall;
	assign cmd_axis_ok = (int'(cmd.axis) < AXES);
	assign in_idx      = AX_W'(cmd.axis);
	assign cmd_idx     = AX_W'(cmd_q.axis);
	assign ax_idx      = ax_q[AX_W-1:0];
	assign cfg_ready   = 1'b1;
	assign set_valid   = set_valid_q;
	assign setpoint    = setpoint_q;
	assign out_free    = !set_valid_q || !set_stall;
	assign op_done     = mul_done || div_done || sq_done;

	// Product scalings, with the Q16.16 truncation and the 2^40 cap on magnitudes.
	assign x16   = mul_prod[P_W-1:16];
	assign x17   = mul_prod[P_W-1:17];
	assign cap16 = ((|x16[63:41]) || (x16[40] && (|x16[39:0]))) ? {1'b1, 40'b0} : x16[40:0];
	assign cap17 = ((|x17[62:41]) || (x17[40] && (|x17[39:0]))) ? {1'b1, 40'b0} : x17[40:0];
	assign prod_clamp17 = (|mul_prod[P_W-1:49]) ? 32'hFFFFFFFF : mul_prod[48:17];
	assign quo_clamp    = (|div_quo[N_W-1:32]) ? 32'hFFFFFFFF : div_quo[31:0];

	// Arm arithmetic.
	assign arm_diff   = 33'(cmd_q.end_pos) - 33'(cmd_q.start_pos);
	assign arm_dist   = arm_diff[32] ? 32'(-arm_diff) : arm_diff[31:0];
	assign twice_sacc = {sacc_q, 1'b0};
	assign sconst     = ({1'b0, d_q} > twice_sacc) ? 32'({1'b0, d_q} - twice_sacc) : 32'd0;
	assign tt_sum     = {1'b0, tacc_q, 1'b0} + {2'b00, tconst_q};
	assign tt_arm     = (|tt_sum[33:32]) ? 32'hFFFFFFFF : tt_sum[31:0];

	// Tick phase arithmetic.
	assign sum_tr  = {1'b0, t_q} + {1'b0, r_q};
	assign two_r   = {r_q, 1'b0};
	assign cr_full = {1'b0, tt_q} - two_r;
	assign el_sum  = {1'b0, t_q} + 33'(time_step_q);
	assign pos_full = 45'(org_q) + 45'(pos_q);

	always_comb begin
		later_active = 1'b0;
		for (int k = 0; k < AXES; k++) begin
			if ((AC_W'(k) > ax_q) && active_q[k]) later_active = 1'b1;
		end
	end

	always_comb begin
		case (phase_q)
			ptp_pkg::PH_ACCEL:  last_step = (step_q == 2'd2);
			ptp_pkg::PH_BRAKE:  last_step = (step_q == 2'd3);
			default:            last_step = 1'b1;
		endcase
	end

	// Next state and unit requests.
	always_comb begin
		state_d   = state_q;
		need_op   = 1'b0;
		mul_start = 1'b0;
		div_start = 1'b0;
		sq_start  = 1'b0;
		mul_a     = {{(A_W-32){1'b0}}, t_q};
		mul_b     = t_q;
		div_num   = {vmax_q, 16'b0};
		div_den   = {1'b0, cmd_q.accel_limit};
		sq_x      = {1'b0, mul_prod[63:1]};
		unique case (state_q)
			ptp_pkg::ST_IDLE: begin
				if (cmd_accept) begin
					if (cmd.func == ptp_pkg::FUNC_TICK) state_d = ptp_pkg::ST_TK_SCAN;
					else if (cmd.func == ptp_pkg::FUNC_ARM && cmd_axis_ok)
						state_d = ptp_pkg::ST_ARM_PREP;
				end
			end
			ptp_pkg::ST_ARM_PREP: begin
				if (cmd_q.accel_limit == 31'd0 || arm_dist == 32'd0)
					state_d = ptp_pkg::ST_ARM_WRITE;
				else
					state_d = ptp_pkg::ST_ARM_MUL_AD;
			end
			ptp_pkg::ST_ARM_MUL_AD: begin
				need_op   = 1'b1;
				mul_start = !issued_q;
				mul_a     = {{(A_W-32){1'b0}}, d_q};
				mul_b     = {1'b0, cmd_q.accel_limit};
				if (mul_done) state_d = ptp_pkg::ST_ARM_SQRT;
			end
			ptp_pkg::ST_ARM_SQRT: begin
				need_op  = 1'b1;
				sq_start = !issued_q;
				if (sq_done)
					state_d = (sq_root == '0) ? ptp_pkg::ST_ARM_WRITE : ptp_pkg::ST_ARM_DIV_T;
			end
			ptp_pkg::ST_ARM_DIV_T: begin
				need_op   = 1'b1;
				div_start = !issued_q;
				if (div_done) state_d = ptp_pkg::ST_ARM_MUL_TT;
			end
			ptp_pkg::ST_ARM_MUL_TT: begin
				need_op   = 1'b1;
				mul_start = !issued_q;
				mul_a     = {{(A_W-32){1'b0}}, tacc_q};
				mul_b     = tacc_q;
				if (mul_done) state_d = ptp_pkg::ST_ARM_MUL_SA;
			end
			ptp_pkg::ST_ARM_MUL_SA: begin
				need_op   = 1'b1;
				mul_start = !issued_q;
				mul_a     = tmp_q;
				mul_b     = {1'b0, cmd_q.accel_limit};
				if (mul_done) state_d = ptp_pkg::ST_ARM_DIV_C;
			end
			ptp_pkg::ST_ARM_DIV_C: begin
				need_op   = 1'b1;
				div_start = !issued_q;
				div_num   = {sconst, 16'b0};
				div_den   = vmax_q;
				if (div_done) state_d = ptp_pkg::ST_ARM_WRITE;
			end
			ptp_pkg::ST_ARM_WRITE: begin
				state_d = ptp_pkg::ST_IDLE;
			end
			ptp_pkg::ST_TK_SCAN: begin
				if (ax_q == AC_W'(AXES)) state_d = ptp_pkg::ST_IDLE;
				else if (active_q[ax_idx]) state_d = ptp_pkg::ST_TK_LOAD;
			end
			ptp_pkg::ST_TK_LOAD: begin
				state_d = ptp_pkg::ST_TK_PHASE;
			end
			ptp_pkg::ST_TK_PHASE: begin
				state_d = ptp_pkg::ST_TK_MUL;
			end
			ptp_pkg::ST_TK_MUL: begin
				need_op   = 1'b1;
				mul_start = !issued_q;
				case (phase_q)
					ptp_pkg::PH_ACCEL: begin
						case (step_q)
							2'd0: begin
								mul_a = {{(A_W-32){1'b0}}, t_q};
								mul_b = t_q;
							end
							2'd1: begin
								mul_a = tmp_q;
								mul_b = {1'b0, a_q};
							end
							default: begin
								mul_a = {{(A_W-32){1'b0}}, t_q};
								mul_b = {1'b0, a_q};
							end
						endcase
					end
					ptp_pkg::PH_CRUISE: begin
						mul_a = {{(A_W-32){1'b0}}, dt_q};
						mul_b = v_q;
					end
					ptp_pkg::PH_BRAKE: begin
						case (step_q)
							2'd0: begin
								mul_a = {{(A_W-32){1'b0}}, cr_q};
								mul_b = v_q;
							end
							2'd1: begin
								mul_a = {{(A_W-32){1'b0}}, dt_q};
								mul_b = {1'b0, a_q};
							end
							2'd2: begin
								mul_a = {{(A_W-32){1'b0}}, left_q};
								mul_b = left_q;
							end
							default: begin
								mul_a = tmp_q;
								mul_b = {1'b0, a_q};
							end
						endcase
					end
					default: begin
						mul_a = {{(A_W-32){1'b0}}, cr_q};
						mul_b = v_q;
					end
				endcase
				if (mul_done && last_step) state_d = ptp_pkg::ST_TK_SIGN;
			end
			ptp_pkg::ST_TK_SIGN: begin
				state_d = ptp_pkg::ST_TK_OUT;
			end
			ptp_pkg::ST_TK_OUT: begin
				if (out_free) state_d = ptp_pkg::ST_TK_SCAN;
			end
			default: begin
				state_d = ptp_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers, configuration and the reset-cleared per-axis state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issued_q    <= 1'b0;
			ax_q        <= '0;
			step_q      <= '0;
			time_step_q <= ptp_pkg::TIME_STEP_RESET;
			set_valid_q <= 1'b0;
			active_q    <= '0;
			sign_q      <= '0;
			for (int k = 0; k < AXES; k++) begin
				origin_q[k]  <= '0;
				accel_q[k]   <= '0;
				total_q[k]   <= '0;
				elapsed_q[k] <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) time_step_q <= cfg_data;

			if (need_op && !issued_q) issued_q <= 1'b1;
			else if (op_done) issued_q <= 1'b0;

			// A new setpoint loads the output register; otherwise it empties when taken.
			if (state_q == ptp_pkg::ST_TK_OUT && out_free) set_valid_q <= 1'b1;
			else if (!set_stall) set_valid_q <= 1'b0;

			unique case (state_q)
				ptp_pkg::ST_IDLE: begin
					ax_q <= '0;
					if (cmd_accept && cmd.func == ptp_pkg::FUNC_CLEAR && cmd_axis_ok) begin
						active_q[in_idx]  <= 1'b0;
						sign_q[in_idx]    <= 1'b0;
						origin_q[in_idx]  <= '0;
						accel_q[in_idx]   <= '0;
						total_q[in_idx]   <= '0;
						elapsed_q[in_idx] <= '0;
					end
				end
				ptp_pkg::ST_ARM_WRITE: begin
					active_q[cmd_idx]  <= 1'b1;
					sign_q[cmd_idx]    <= neg_q;
					origin_q[cmd_idx]  <= cmd_q.start_pos;
					accel_q[cmd_idx]   <= cmd_q.accel_limit;
					total_q[cmd_idx]   <= tt_arm;
					elapsed_q[cmd_idx] <= '0;
				end
				ptp_pkg::ST_TK_SCAN: begin
					if (ax_q != AC_W'(AXES) && !active_q[ax_idx]) ax_q <= ax_q + 1'b1;
				end
				ptp_pkg::ST_TK_PHASE: begin
					step_q <= '0;
				end
				ptp_pkg::ST_TK_MUL: begin
					if (mul_done) step_q <= step_q + 1'b1;
				end
				ptp_pkg::ST_TK_OUT: begin
					if (out_free) begin
						elapsed_q[ax_idx] <= el_sum[32] ? 32'hFFFFFFFF : el_sum[31:0];
						if (phase_q == ptp_pkg::PH_DONE) active_q[ax_idx] <= 1'b0;
						ax_q <= ax_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Profile values that are read only after an arm has written them.
	always_ff @(posedge clk) begin
		if (state_q == ptp_pkg::ST_ARM_WRITE) begin
			peak_q[cmd_idx]   <= vmax_q;
			ramp_t_q[cmd_idx] <= tacc_q;
			ramp_d_q[cmd_idx] <= sacc_q;
		end
	end

	// Datapath working registers.
	always_ff @(posedge clk) begin
		if (cmd_accept) cmd_q <= cmd;

		case (state_q)
			ptp_pkg::ST_ARM_PREP: begin
				d_q      <= arm_dist;
				neg_q    <= arm_diff[32];
				vmax_q   <= '0;
				tacc_q   <= '0;
				sacc_q   <= '0;
				tconst_q <= '0;
			end
			ptp_pkg::ST_ARM_SQRT: begin
				if (sq_done) vmax_q <= sq_root;
			end
			ptp_pkg::ST_ARM_DIV_T: begin
				if (div_done) tacc_q <= quo_clamp;
			end
			ptp_pkg::ST_ARM_MUL_TT: begin
				if (mul_done) tmp_q <= mul_prod[63:16];
			end
			ptp_pkg::ST_ARM_MUL_SA: begin
				if (mul_done) sacc_q <= prod_clamp17;
			end
			ptp_pkg::ST_ARM_DIV_C: begin
				if (div_done) tconst_q <= quo_clamp;
			end
			ptp_pkg::ST_TK_LOAD: begin
				t_q   <= elapsed_q[ax_idx];
				r_q   <= ramp_t_q[ax_idx];
				tt_q  <= total_q[ax_idx];
				a_q   <= accel_q[ax_idx];
				v_q   <= peak_q[ax_idx];
				sa_q  <= ramp_d_q[ax_idx];
				org_q <= origin_q[ax_idx];
				sgn_q <= sign_q[ax_idx];
			end
			ptp_pkg::ST_TK_PHASE: begin
				// Cruise distance uses T - 2r floored at zero.
				cr_q   <= cr_full[32] ? 32'd0 : cr_full[31:0];
				left_q <= tt_q - t_q;
				pos_q  <= '0;
				vel_q  <= '0;
				acc_q  <= '0;
				if (tt_q == 32'd0 || t_q > tt_q) begin
					phase_q <= ptp_pkg::PH_DONE;
					dt_q    <= '0;
				end else if (t_q <= r_q) begin
					phase_q <= ptp_pkg::PH_ACCEL;
					acc_q   <= {2'b00, a_q};
					dt_q    <= '0;
				end else if (sum_tr <= {1'b0, tt_q}) begin
					phase_q <= ptp_pkg::PH_CRUISE;
					vel_q   <= {12'b0, v_q};
					dt_q    <= t_q - r_q;
				end else begin
					phase_q <= ptp_pkg::PH_BRAKE;
					acc_q   <= 33'd0 - {2'b00, a_q};
					dt_q    <= 32'(sum_tr - {1'b0, tt_q});
				end
			end
			ptp_pkg::ST_TK_MUL: begin
				if (mul_done) begin
					case (phase_q)
						ptp_pkg::PH_ACCEL: begin
							case (step_q)
								2'd0:    tmp_q <= mul_prod[63:16];
								2'd1:    pos_q <= {3'b0, cap17};
								default: vel_q <= {3'b0, cap16};
							endcase
						end
						ptp_pkg::PH_CRUISE: begin
							pos_q <= {12'b0, sa_q} + {3'b0, cap16};
						end
						ptp_pkg::PH_BRAKE: begin
							case (step_q)
								2'd0:    pos_q <= {11'b0, sa_q, 1'b0} + {3'b0, cap16};
								2'd1:    vel_q <= {12'b0, v_q} - {3'b0, cap16};
								2'd2:    tmp_q <= mul_prod[63:16];
								default: pos_q <= pos_q - {3'b0, cap17};
							endcase
						end
						default: begin
							// A zero-length profile stays at the start point.
							if (tt_q == 32'd0) pos_q <= '0;
							else pos_q <= {11'b0, sa_q, 1'b0} + {3'b0, cap16};
						end
					endcase
				end
			end
			ptp_pkg::ST_TK_SIGN: begin
				if (sgn_q) begin
					pos_q <= -pos_q;
					vel_q <= -vel_q;
					acc_q <= -acc_q;
				end
			end
			ptp_pkg::ST_TK_OUT: begin
				if (out_free) begin
					setpoint_q.out_axis     <= ax_q[1:0];
					setpoint_q.position     <= sat32(pos_full);
					setpoint_q.velocity     <= sat32(45'(vel_q));
					setpoint_q.acceleration <= sat32(45'(acc_q));
					setpoint_q.done_res     <= (phase_q == ptp_pkg::PH_DONE);
					setpoint_q.last         <= !later_active;
				end
			end
			default: begin
			end
		endcase
	end

	ptp_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	ptp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	ptp_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.x      (sq_x),
		.done   (sq_done),
		.root   (sq_root)
	);

endmodule
